### hw/rtl/tmrh_pkg.sv
// ---------------------------------------------------------------------------
// Touch map and region hit test package
// Shared constants, payload structs, control structs and the sequencer
// states of the touch mapping and region hit test unit.
// ---------------------------------------------------------------------------
package tmrh_pkg;

  // Region table size and the index widths that follow from it.
  localparam int REGION_COUNT = 16;
  localparam int RIDX_W       = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
  localparam int RCNT_W       = $clog2(REGION_COUNT + 1);

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SCALE_X  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SCALE_Y  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_X = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_Y = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_HEIGHT   = 3'd5;

  // Register reset values.
  localparam logic [15:0] DEBOUNCE_RST = 16'd200;
  localparam logic [19:0] SCALE_RST    = 20'd4096;
  localparam logic [11:0] OFFSET_RST   = 12'd0;
  localparam logic [11:0] HEIGHT_RST   = 12'd320;

  // Item modes.
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_TOUCH  = 2'd1;
  localparam logic [1:0] MODE_REGION = 2'd2;

  // Fixed-point widths of the mapping datapath.
  localparam int FRAC_W = 16;
  localparam int PROD_W = 34;
  localparam int Q_W    = 35;

  // Tick counter saturation value.
  localparam logic [15:0] MS_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]         mode;
    logic [11:0]        raw_x;
    logic [11:0]        raw_y;
    logic [3:0]         slot;
    logic signed [15:0] left_bound;
    logic signed [15:0] right_bound;
    logic signed [15:0] top_bound;
    logic signed [15:0] bottom_bound;
    logic               slot_enabled;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic               hit;
    logic [3:0]         hit_slot;
  } out_item_t;

  // One entry of the region bounds memory.
  typedef struct packed {
    logic signed [15:0] bottom;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] left;
  } region_bounds_t;

  typedef struct packed {
    logic [19:0] scale_x;
    logic [19:0] scale_y;
    logic [11:0] offset_x;
    logic [11:0] offset_y;
    logic [11:0] screen_height;
  } map_cfg_t;

  typedef struct packed {
    logic           valid;
    logic [3:0]     slot;
    region_bounds_t bounds;
    logic           enable;
  } region_wr_t;

  typedef struct packed {
    logic       done;
    logic       hit;
    logic [3:0] hit_slot;
  } scan_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAP,
    ST_SCAN,
    ST_DONE
  } tmrh_state_t;

endpackage

### hw/rtl/tmrh_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ---------------------------------------------------------------------------
module tmrh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/tmrh_map.sv
// ---------------------------------------------------------------------------
// Touch coordinate mapper
// Three-stage pipeline: offset and scale products, vertical flip, then
// truncation toward zero and saturation to signed 16 bits.
// ---------------------------------------------------------------------------
module tmrh_map
  import tmrh_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [11:0]        raw_x,
  input  logic [11:0]        raw_y,
  input  map_cfg_t           cfg,
  output logic               done,
  output logic signed [15:0] screen_x,
  output logic signed [15:0] screen_y
);

  localparam int WHOLE_W = Q_W - FRAC_W;
  localparam logic signed [WHOLE_W-1:0] S16_MAX = WHOLE_W'(32'sd32767);
  localparam logic signed [WHOLE_W-1:0] S16_MIN = WHOLE_W'(-32'sd32768);

  // Truncate a Q16 value toward zero and clamp it to signed 16 bits.
  function automatic logic signed [15:0] q16_to_s16(input logic signed [Q_W-1:0] q);
    logic signed [Q_W-1:0]     biased;
    logic signed [WHOLE_W-1:0] whole;
    biased = q + $signed({{(Q_W - FRAC_W){1'b0}}, {FRAC_W{q[Q_W-1]}}});
    whole  = biased[Q_W-1:FRAC_W];
    if (whole > S16_MAX) begin
      return 16'sh7FFF;
    end else if (whole < S16_MIN) begin
      return -16'sh8000;
    end
    return whole[15:0];
  endfunction

  logic v1_r, v2_r, v3_r;
  logic signed [12:0]       diff_x, diff_y;
  logic signed [PROD_W-1:0] px_r, py_r;
  logic [11:0]              hgt_r;
  logic signed [Q_W-1:0]    qx_r, qy_r;
  logic signed [15:0]       sx_r, sy_r;

  // Raw offsets; screen x comes from raw y and screen y from raw x.
  assign diff_x = $signed({1'b0, raw_y}) - $signed({1'b0, cfg.offset_x});
  assign diff_y = $signed({1'b0, raw_x}) - $signed({1'b0, cfg.offset_y});

  // Stage valid pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Datapath stages.
  always_ff @(posedge clk) begin
    px_r  <= diff_x * $signed({1'b0, cfg.scale_x});
    py_r  <= diff_y * $signed({1'b0, cfg.scale_y});
    hgt_r <= cfg.screen_height;
    qx_r  <= Q_W'(px_r);
    qy_r  <= $signed(Q_W'({hgt_r, {FRAC_W{1'b0}}})) - Q_W'(py_r);
    sx_r  <= q16_to_s16(qx_r);
    sy_r  <= q16_to_s16(qy_r);
  end

  assign done     = v3_r;
  assign screen_x = sx_r;
  assign screen_y = sy_r;

endmodule

### hw/rtl/tmrh_region.sv
// ---------------------------------------------------------------------------
// Region table and hit scanner
// Holds region bounds in a RAM and enables in flops, and scans the table
// in index order for the first enabled region that holds a point.
// ---------------------------------------------------------------------------
module tmrh_region
  import tmrh_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  region_wr_t         wr,
  input  logic               start,
  input  logic signed [15:0] pt_x,
  input  logic signed [15:0] pt_y,
  output scan_res_t          res
);

  logic [REGION_COUNT-1:0] en_r;
  logic                    busy_r, busy_nxt;
  logic [RCNT_W-1:0]       rd_cnt_r, rd_cnt_nxt;
  logic                    chk_v_r, chk_v_nxt;
  logic [RIDX_W-1:0]       chk_idx_r, chk_idx_nxt;
  logic signed [15:0]      px_r, py_r;
  scan_res_t               res_r, res_nxt;
  logic                    wr_ok;
  logic [RIDX_W-1:0]       waddr;
  logic [RIDX_W-1:0]       raddr;
  region_bounds_t          rdata;
  logic                    inside_pt;

  assign wr_ok = wr.valid && (32'(wr.slot) < REGION_COUNT);
  assign waddr = RIDX_W'(wr.slot);
  assign raddr = rd_cnt_r[RIDX_W-1:0];

  tmrh_ram #(
    .WIDTH($bits(region_bounds_t)),
    .DEPTH(REGION_COUNT)
  ) u_bounds_ram (
    .clk  (clk),
    .we   (wr_ok),
    .waddr(waddr),
    .wdata(wr.bounds),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Enable flags, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= '0;
    end else if (wr_ok) begin
      en_r[waddr] <= wr.enable;
    end
  end

  // Half-open containment test on the entry read last cycle.
  assign inside_pt = en_r[chk_idx_r] &&
                     (px_r >= rdata.left) && (px_r < rdata.right) &&
                     (py_r >= rdata.top) && (py_r < rdata.bottom);

  // Scan sequencing: one read issued and one entry tested per cycle.
  always_comb begin
    busy_nxt    = busy_r;
    rd_cnt_nxt  = rd_cnt_r;
    chk_v_nxt   = 1'b0;
    chk_idx_nxt = chk_idx_r;
    res_nxt     = '0;
    if (start) begin
      busy_nxt   = 1'b1;
      rd_cnt_nxt = '0;
    end else if (busy_r) begin
      if (32'(rd_cnt_r) < REGION_COUNT) begin
        rd_cnt_nxt  = rd_cnt_r + RCNT_W'(1);
        chk_v_nxt   = 1'b1;
        chk_idx_nxt = raddr;
      end
      if (chk_v_r) begin
        if (inside_pt) begin
          busy_nxt         = 1'b0;
          chk_v_nxt        = 1'b0;
          res_nxt.done     = 1'b1;
          res_nxt.hit      = 1'b1;
          res_nxt.hit_slot = 4'(chk_idx_r);
        end else if (chk_idx_r == RIDX_W'(REGION_COUNT - 1)) begin
          busy_nxt     = 1'b0;
          chk_v_nxt    = 1'b0;
          res_nxt.done = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      chk_v_r  <= 1'b0;
      rd_cnt_r <= '0;
      res_r    <= '0;
    end else begin
      busy_r   <= busy_nxt;
      chk_v_r  <= chk_v_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      res_r    <= res_nxt;
    end
  end

  // Point and index registers carry no reset.
  always_ff @(posedge clk) begin
    chk_idx_r <= chk_idx_nxt;
    if (start) begin
      px_r <= pt_x;
      py_r <= pt_y;
    end
  end

  assign res = res_r;

  // A reported hit names an enabled region.
  a_hit_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (res_r.done && res_r.hit) |-> en_r[RIDX_W'(res_r.hit_slot)])
    else $error("hit reported on a disabled region");

  // When a result is reported, the scan is no longer busy.
  a_done_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
    res_r.done |-> !busy_r)
    else $error("scan still busy after its result");

endmodule

### hw/rtl/touch_map_and_region_hit_test_unit.sv
// ---------------------------------------------------------------------------
// Touch map and region hit test unit
// Debounces touch samples, maps them to screen coordinates and finds the
// first enabled region of the region table that holds the point.
// ---------------------------------------------------------------------------
// Usage:
// Items enter on in_valid/in_ready and carry a mode: a millisecond tick, a
// touch sample or a region table write. Every item yields exactly one
// result item on out_valid/out_ready. Registers are written on cfg_we with
// cfg_addr and cfg_wdata; the user must write them only while the unit is
// idle, which the block itself does not enforce. A tick, a region write
// or a touch rejected by debounce skips the mapping and the scan. An
// accepted touch passes the mapping pipeline and then the region scan,
// which reads one bounds RAM entry a cycle in index order through the
// single read port of the region RAM and stops at the first region that
// holds the point, or after the last region when none does.
// One item is worked on at a time; the next is taken as soon as the result
// has moved to the output register, even while that result waits.
// Reset loads the register defaults, clears the tick counter and all region
// enables; region bounds are left as they are. A stalled receiver holds the
// result in the output register and the unit stops before loading the next.
// ---------------------------------------------------------------------------
module touch_map_and_region_hit_test_unit
  import tmrh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  tmrh_state_t state_r, state_nxt;
  logic [15:0] ms_r, ms_nxt;
  logic [15:0] debounce_r;
  map_cfg_t    map_cfg_r;
  out_item_t   res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r;
  logic        in_fire;
  logic        out_free;
  logic        map_start;
  logic        map_done;
  logic signed [15:0] map_sx, map_sy;
  logic        scan_start;
  scan_res_t   scan_res;
  region_wr_t  region_wr;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r              <= DEBOUNCE_RST;
      map_cfg_r.scale_x       <= SCALE_RST;
      map_cfg_r.scale_y       <= SCALE_RST;
      map_cfg_r.offset_x      <= OFFSET_RST;
      map_cfg_r.offset_y      <= OFFSET_RST;
      map_cfg_r.screen_height <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DEBOUNCE: debounce_r              <= cfg_wdata[15:0];
        CFG_SCALE_X:  map_cfg_r.scale_x       <= cfg_wdata;
        CFG_SCALE_Y:  map_cfg_r.scale_y       <= cfg_wdata;
        CFG_OFFSET_X: map_cfg_r.offset_x      <= cfg_wdata[11:0];
        CFG_OFFSET_Y: map_cfg_r.offset_y      <= cfg_wdata[11:0];
        CFG_HEIGHT:   map_cfg_r.screen_height <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // Region table writes go straight to the region store.
  always_comb begin
    region_wr.valid         = in_fire && (in_data.mode == MODE_REGION);
    region_wr.slot          = in_data.slot;
    region_wr.bounds.left   = in_data.left_bound;
    region_wr.bounds.right  = in_data.right_bound;
    region_wr.bounds.top    = in_data.top_bound;
    region_wr.bounds.bottom = in_data.bottom_bound;
    region_wr.enable        = in_data.slot_enabled;
  end

  tmrh_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (map_start),
    .raw_x   (in_data.raw_x),
    .raw_y   (in_data.raw_y),
    .cfg     (map_cfg_r),
    .done    (map_done),
    .screen_x(map_sx),
    .screen_y(map_sy)
  );

  tmrh_region u_region (
    .clk  (clk),
    .rst_n(rst_n),
    .wr   (region_wr),
    .start(scan_start),
    .pt_x (map_sx),
    .pt_y (map_sy),
    .res  (scan_res)
  );

  // Sequencer: next state, counter update and result assembly.
  always_comb begin
    state_nxt     = state_r;
    ms_nxt        = ms_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    map_start     = 1'b0;
    scan_start    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_nxt   = '0;
          state_nxt = ST_DONE;
          case (in_data.mode)
            MODE_TICK: begin
              if (ms_r != MS_MAX) begin
                ms_nxt = ms_r + 16'd1;
              end
            end
            MODE_TOUCH: begin
              if (ms_r > debounce_r) begin
                ms_nxt           = '0;
                map_start        = 1'b1;
                res_nxt.accepted = 1'b1;
                state_nxt        = ST_MAP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MAP: begin
        if (map_done) begin
          res_nxt.screen_x = map_sx;
          res_nxt.screen_y = map_sy;
          scan_start       = 1'b1;
          state_nxt        = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          res_nxt.hit      = scan_res.hit;
          res_nxt.hit_slot = scan_res.hit_slot;
          state_nxt        = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ms_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ms_r        <= ms_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result and output payload registers.
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An accepted touch restarts the debounce counter.
  a_touch_clears_ms: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.mode == MODE_TOUCH && ms_r > debounce_r) |=> (ms_r == '0))
    else $error("debounce counter not cleared by an accepted touch");

  // A finished result is not dropped while the output slot is occupied.
  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && !out_ready) |=> (state_r == ST_DONE))
    else $error("result left the sequencer while the output was stalled");

  // Items that were not mapped carry an all-zero result.
  a_zero_when_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.accepted) |->
      (out_data_r.screen_x == '0 && out_data_r.screen_y == '0 &&
       !out_data_r.hit && out_data_r.hit_slot == '0))
    else $error("nonzero fields on a result with no accepted touch");

endmodule
